[rtl/crsp_pkg.sv]
// Package for the cached resumable shortest-path core.
// Holds sizes, codes, storage word types, the sequencer state type and the heap key compare.
// Depends on nothing.
`default_nettype none
package crsp_pkg;
    localparam int VERTICES   = 64;
    localparam int MAX_DEGREE = 8;
    localparam int HEAP_DEPTH = 256;
    localparam int DIST_WIDTH = 32;

    localparam int V_W    = $clog2(VERTICES);
    localparam int DEG_W  = $clog2(MAX_DEGREE);
    localparam int HEAP_W = $clog2(HEAP_DEPTH);
    localparam int CNT_W  = HEAP_W + 1;
    localparam int ADJ_AW = V_W + DEG_W;
    localparam int ENT_AW = 2 * V_W;
    localparam int HP_AW  = V_W + HEAP_W;

    localparam logic [DIST_WIDTH-1:0] DIST_INF = '1;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_PRED  = 2'd2;
    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_UNREACH  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic                  present;
        logic [V_W-1:0]        nbr;
        logic [DIST_WIDTH-1:0] len;
    } t_adj;

    typedef struct packed {
        logic                  settled;
        logic [DIST_WIDTH-1:0] path_len;
        logic [V_W-1:0]        parent;
    } t_entry;

    typedef struct packed {
        logic [V_W-1:0]        vtx;
        logic [DIST_WIDTH-1:0] key;
    } t_hent;

    typedef struct packed {
        logic                  pred_valid;
        logic [V_W-1:0]        pred;
        logic [1:0]            status;
        logic                  hit;
        logic [DIST_WIDTH-1:0] path_len;
    } t_result;

    typedef enum logic [4:0] {
        S_ADJCLR, S_IDLE, S_RD, S_Q0, S_CLR, S_INIT,
        S_POP0, S_POP1, S_POP2, S_SDA, S_SDB, S_SDC, S_SDD,
        S_CHK0, S_CHK1, S_RXA, S_RXB, S_RXC, S_SUA, S_SUB,
        S_FIN, S_FIN2, S_OUT
    } t_state;

    function automatic logic key_less(input t_hent a, input t_hent b);
        return (a.key < b.key) || ((a.key == b.key) && (a.vtx < b.vtx));
    endfunction
endpackage
`default_nettype wire

[rtl/cached_resumable_shortest_path_core.sv]
// Top level of the cached resumable shortest-path core: sequencer, heap, graph and search stores.
// Depends on crsp_pkg.
`default_nettype none
// After reset the block sweeps all 512 entries of the adjacency store before it takes its first
// transaction. A query that starts a search first clears the source's 64-entry row. Each heap
// pop then runs its pop states and up to one sift-down pass per level, and each present edge
// a relax step with one sift-up pass per level when it pushes, all through one heap memory,
// so the length of a query follows the graph and the cached state. One transaction is in work
// at a time; a finished result waits in the output register while the next one is accepted.
module cached_resumable_shortest_path_core
    import crsp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // vertex_a, vertex_b, slot, neighbor, edge_length, slot_valid, zero fill
    input  wire logic [55:0] s_tdata,
    // opcode
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // distance, cache_hit, status, predecessor, predecessor_valid, zero fill
    output logic [47:0]      m_tdata
);
    t_state r_state, n_state;
    logic [V_W-1:0] r_s, n_s, r_t, n_t, r_u, n_u, r_w, n_w;
    logic [ADJ_AW-1:0] r_i, n_i;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [HEAP_W-1:0] r_hi, n_hi, r_chi, n_chi;
    t_hent r_cur, n_cur, r_ch, n_ch;
    logic [DIST_WIDTH-1:0] r_bu, n_bu, r_nd, n_nd;
    logic [DEG_W:0] r_j, n_j;
    logic r_found, n_found;
    t_result r_res, n_res, r_odata, n_odata;
    logic r_ovalid, n_ovalid;
    logic [VERTICES-1:0] r_started, n_started, r_live, n_live;

    t_adj   adj_mem [2**ADJ_AW];
    t_entry ent_mem [2**ENT_AW];
    t_hent  hp_mem  [2**HP_AW];
    logic [CNT_W-1:0] hc_mem [VERTICES];

    logic adj_we, ent_we, hp_we, hc_we;
    logic [ADJ_AW-1:0] adj_wa, adj_ra;
    logic [ENT_AW-1:0] ent_wa, ent_ra;
    logic [HP_AW-1:0] hp_wa, hp_ra;
    logic [V_W-1:0] hc_wa, hc_ra;
    t_adj adj_wd, r_ard;
    t_entry ent_wd, r_erd;
    t_hent hp_wd, r_hrd;
    logic [CNT_W-1:0] hc_wd, r_hcrd;

    logic accept;
    logic [1:0] in_op;
    logic [V_W-1:0] in_a, in_b, in_nbr, in_min, in_max;
    logic [DEG_W-1:0] in_slot;
    logic [DIST_WIDTH-1:0] in_len;
    logic in_valid;
    logic [HEAP_W+1:0] w_l, w_r;
    logic [HEAP_W-1:0] w_p;
    logic [DIST_WIDTH:0] w_sum;
    logic out_free;

    assign in_a     = s_tdata[5:0];
    assign in_b     = s_tdata[11:6];
    assign in_slot  = s_tdata[14:12];
    assign in_nbr   = s_tdata[20:15];
    assign in_len   = s_tdata[52:21];
    assign in_valid = s_tdata[53];
    assign in_op    = s_tuser;
    assign in_min   = (in_a < in_b) ? in_a : in_b;
    assign in_max   = (in_a < in_b) ? in_b : in_a;

    assign s_tready = (r_state == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = r_ovalid;
    assign m_tdata  = {6'b0, r_odata};
    assign out_free = !r_ovalid || m_tready;

    assign w_l   = {1'b0, r_hi, 1'b1};
    assign w_r   = w_l + (HEAP_W+2)'(1);
    assign w_p   = (r_hi - HEAP_W'(1)) >> 1;
    assign w_sum = {1'b0, r_bu} + {1'b0, r_ard.len};

    function automatic t_result entry_result(input t_entry e, input logic hit,
                                             input logic ok);
        t_result res;
        res.path_len   = ok ? e.path_len : DIST_INF;
        res.hit        = hit;
        res.status     = ok ? ST_OK : ST_UNREACH;
        res.pred_valid = (e.path_len != DIST_INF);
        res.pred       = (e.path_len != DIST_INF) ? e.parent : '0;
        return res;
    endfunction

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_ADJCLR: if (r_i == ADJ_AW'(2**ADJ_AW - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (accept) begin
                    unique case (in_op)
                        OP_QUERY: n_state = S_Q0;
                        OP_PRED:  n_state = S_RD;
                        default:  n_state = S_OUT;
                    endcase
                end
            end
            S_RD: n_state = S_OUT;
            S_Q0: begin
                if (r_live[r_s] && r_erd.settled) n_state = S_OUT;
                else if (!r_started[r_s]) n_state = S_CLR;
                else n_state = S_POP0;
            end
            S_CLR:  if (r_i[V_W-1:0] == V_W'(VERTICES - 1)) n_state = S_INIT;
            S_INIT: n_state = S_POP0;
            S_POP0: n_state = (r_cnt == '0) ? S_FIN : S_POP1;
            S_POP1: n_state = S_POP2;
            S_POP2: n_state = S_SDA;
            S_SDA:  n_state = (w_l >= {1'b0, r_cnt}) ? S_CHK0 : S_SDB;
            S_SDB:  n_state = (w_r < {1'b0, r_cnt}) ? S_SDC : S_SDD;
            S_SDC:  n_state = S_SDD;
            S_SDD:  n_state = key_less(r_ch, r_cur) ? S_SDA : S_CHK0;
            S_CHK0: n_state = S_CHK1;
            S_CHK1: n_state = r_erd.settled ? S_POP0 : S_RXA;
            S_RXA: begin
                if (r_j == (DEG_W+1)'(MAX_DEGREE)) n_state = (r_u == r_t) ? S_FIN : S_POP0;
                else n_state = S_RXB;
            end
            S_RXB: n_state = r_ard.present ? S_RXC : S_RXA;
            S_RXC: begin
                if (r_erd.settled || !(r_nd < r_erd.path_len)) n_state = S_RXA;
                else if (r_cnt == CNT_W'(HEAP_DEPTH)) n_state = S_OUT;
                else n_state = S_SUA;
            end
            S_SUA:  n_state = (r_hi == '0) ? S_RXA : S_SUB;
            S_SUB:  n_state = key_less(r_cur, r_hrd) ? S_SUA : S_RXA;
            S_FIN:  n_state = S_FIN2;
            S_FIN2: n_state = S_OUT;
            S_OUT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_s = r_s; n_t = r_t; n_u = r_u; n_w = r_w; n_i = r_i; n_cnt = r_cnt;
        n_hi = r_hi; n_chi = r_chi; n_cur = r_cur; n_ch = r_ch; n_bu = r_bu;
        n_nd = r_nd; n_j = r_j; n_found = r_found; n_res = r_res;
        n_started = r_started; n_live = r_live; n_odata = r_odata;
        n_ovalid = r_ovalid && !m_tready;
        adj_we = 1'b0; adj_wa = '0; adj_wd = '0; adj_ra = '0;
        ent_we = 1'b0; ent_wa = '0; ent_wd = '0; ent_ra = '0;
        hp_we = 1'b0; hp_wa = '0; hp_wd = '0; hp_ra = '0;
        hc_we = 1'b0; hc_wa = '0; hc_wd = '0; hc_ra = '0;
        unique case (r_state)
            S_ADJCLR: begin
                adj_we = 1'b1;
                adj_wa = r_i;
                n_i = r_i + ADJ_AW'(1);
            end
            S_IDLE: begin
                if (accept) begin
                    n_res = '0;
                    unique case (in_op)
                        OP_LOAD: begin
                            adj_we = 1'b1;
                            adj_wa = {in_a, in_slot};
                            adj_wd = '{present: in_valid, nbr: in_nbr, len: in_len};
                            n_started = '0;
                            n_live = '0;
                        end
                        OP_QUERY: begin
                            n_s = in_min;
                            n_t = in_max;
                            ent_ra = {in_min, in_max};
                            hc_ra = in_min;
                        end
                        OP_PRED: begin
                            n_s = in_a;
                            n_t = in_b;
                            ent_ra = {in_a, in_b};
                        end
                        default: ;
                    endcase
                end
            end
            S_RD: begin
                if (r_live[r_s]) begin
                    n_res = entry_result(r_erd, r_erd.settled, r_erd.path_len != DIST_INF);
                end else begin
                    n_res = '0;
                    n_res.path_len = DIST_INF;
                    n_res.status = ST_UNREACH;
                end
            end
            S_Q0: begin
                n_i = '0;
                n_cnt = r_hcrd;
                if (r_live[r_s] && r_erd.settled) n_res = entry_result(r_erd, 1'b1, 1'b1);
            end
            S_CLR: begin
                ent_we = 1'b1;
                ent_wa = {r_s, r_i[V_W-1:0]};
                ent_wd = '{settled: 1'b0, path_len: DIST_INF, parent: '0};
                n_i = r_i + ADJ_AW'(1);
            end
            S_INIT: begin
                ent_we = 1'b1;
                ent_wa = {r_s, r_s};
                ent_wd = '{settled: 1'b0, path_len: '0, parent: r_s};
                hp_we = 1'b1;
                hp_wa = {r_s, HEAP_W'(0)};
                hp_wd = '{vtx: r_s, key: '0};
                n_cnt = CNT_W'(1);
                n_started[r_s] = 1'b1;
                n_live[r_s] = 1'b1;
            end
            S_POP0: begin
                hp_ra = {r_s, HEAP_W'(0)};
                n_found = 1'b0;
            end
            S_POP1: begin
                n_u = r_hrd.vtx;
                n_cnt = r_cnt - CNT_W'(1);
                hp_ra = {r_s, HEAP_W'(r_cnt - CNT_W'(1))};
            end
            S_POP2: begin
                n_cur = r_hrd;
                n_hi = '0;
            end
            S_SDA: begin
                if (w_l >= {1'b0, r_cnt}) begin
                    hp_we = 1'b1;
                    hp_wa = {r_s, r_hi};
                    hp_wd = r_cur;
                end else begin
                    hp_ra = {r_s, w_l[HEAP_W-1:0]};
                end
            end
            S_SDB: begin
                n_ch = r_hrd;
                n_chi = w_l[HEAP_W-1:0];
                hp_ra = {r_s, w_r[HEAP_W-1:0]};
            end
            S_SDC: begin
                if (key_less(r_hrd, r_ch)) begin
                    n_ch = r_hrd;
                    n_chi = w_r[HEAP_W-1:0];
                end
            end
            S_SDD: begin
                hp_we = 1'b1;
                hp_wa = {r_s, r_hi};
                if (key_less(r_ch, r_cur)) begin
                    hp_wd = r_ch;
                    n_hi = r_chi;
                end else begin
                    hp_wd = r_cur;
                end
            end
            S_CHK0: ent_ra = {r_s, r_u};
            S_CHK1: begin
                n_bu = r_erd.path_len;
                n_j = '0;
                if (!r_erd.settled) begin
                    ent_we = 1'b1;
                    ent_wa = {r_s, r_u};
                    ent_wd = '{settled: 1'b1, path_len: r_erd.path_len, parent: r_erd.parent};
                end
            end
            S_RXA: begin
                adj_ra = {r_u, r_j[DEG_W-1:0]};
                if (r_j == (DEG_W+1)'(MAX_DEGREE)) n_found = 1'b1;
            end
            S_RXB: begin
                n_w = r_ard.nbr;
                n_nd = w_sum[DIST_WIDTH] ? DIST_INF : w_sum[DIST_WIDTH-1:0];
                ent_ra = {r_s, r_ard.nbr};
                if (!r_ard.present) n_j = r_j + (DEG_W+1)'(1);
            end
            S_RXC: begin
                if (r_erd.settled || !(r_nd < r_erd.path_len)) begin
                    n_j = r_j + (DEG_W+1)'(1);
                end else begin
                    ent_we = 1'b1;
                    ent_wa = {r_s, r_w};
                    ent_wd = '{settled: 1'b0, path_len: r_nd, parent: r_u};
                    if (r_cnt == CNT_W'(HEAP_DEPTH)) begin
                        n_started[r_s] = 1'b0;
                        n_res = '0;
                        n_res.path_len = DIST_INF;
                        n_res.status = ST_OVERFLOW;
                    end else begin
                        n_cur = '{vtx: r_w, key: r_nd};
                        n_hi = r_cnt[HEAP_W-1:0];
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                end
            end
            S_SUA: begin
                if (r_hi == '0) begin
                    hp_we = 1'b1;
                    hp_wa = {r_s, r_hi};
                    hp_wd = r_cur;
                    n_j = r_j + (DEG_W+1)'(1);
                end else begin
                    hp_ra = {r_s, w_p};
                    n_chi = w_p;
                end
            end
            S_SUB: begin
                hp_we = 1'b1;
                hp_wa = {r_s, r_hi};
                if (key_less(r_cur, r_hrd)) begin
                    hp_wd = r_hrd;
                    n_hi = r_chi;
                end else begin
                    hp_wd = r_cur;
                    n_j = r_j + (DEG_W+1)'(1);
                end
            end
            S_FIN: begin
                ent_ra = {r_s, r_t};
                hc_we = 1'b1;
                hc_wa = r_s;
                hc_wd = r_cnt;
            end
            S_FIN2: n_res = entry_result(r_erd, 1'b0, r_found);
            S_OUT: begin
                if (out_free) begin
                    n_odata = r_res;
                    n_ovalid = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ADJCLR;
            r_i <= '0;
            r_ovalid <= 1'b0;
            r_started <= '0;
            r_live <= '0;
        end else begin
            r_state <= n_state;
            r_i <= n_i;
            r_ovalid <= n_ovalid;
            r_started <= n_started;
            r_live <= n_live;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s <= n_s; r_t <= n_t; r_u <= n_u; r_w <= n_w; r_cnt <= n_cnt;
        r_hi <= n_hi; r_chi <= n_chi; r_cur <= n_cur; r_ch <= n_ch;
        r_bu <= n_bu; r_nd <= n_nd; r_j <= n_j; r_found <= n_found;
        r_res <= n_res; r_odata <= n_odata;
    end

    always_ff @(posedge i_clk) begin
        if (adj_we) adj_mem[adj_wa] <= adj_wd;
        r_ard <= adj_mem[adj_ra];
    end

    always_ff @(posedge i_clk) begin
        if (ent_we) ent_mem[ent_wa] <= ent_wd;
        r_erd <= ent_mem[ent_ra];
    end

    always_ff @(posedge i_clk) begin
        if (hp_we) hp_mem[hp_wa] <= hp_wd;
        r_hrd <= hp_mem[hp_ra];
    end

    always_ff @(posedge i_clk) begin
        if (hc_we) hc_mem[hc_wa] <= hc_wd;
        r_hcrd <= hc_mem[hc_ra];
    end
endmodule
`default_nettype wire
